@@ rtl/vrw_pkg.sv @@
// Shared types and constants for the voxel ray walker.
// Depends on nothing; every other file of the block imports it.
package vrw_pkg;

    // Grid and number format
    localparam int GRID_SIZE  = 32;
    localparam int FRAC_BITS  = 9;
    localparam int COORD_BITS = 11;

    // Derived widths
    localparam int START_W = COORD_BITS - 1;              // start index
    localparam int DIFF_W  = COORD_BITS + 1;              // signed axis difference
    localparam int MAG_W   = COORD_BITS;                  // |difference|, step count
    localparam int QUOT_W  = FRAC_BITS + 1;               // increment magnitude
    localparam int INC_W   = QUOT_W + 1;                  // signed increment
    localparam int NUM_W   = MAG_W + FRAC_BITS + 2;       // divider dividend
    localparam int DEN_W   = MAG_W + 1;                   // divider divisor
    localparam int REM_W   = DEN_W + 1;                   // partial remainder
    localparam int CNT_W   = $clog2(QUOT_W);              // divider iteration count
    localparam int CELL_W  = $clog2(GRID_SIZE);           // in-grid cell index
    localparam int KW      = $clog2(GRID_SIZE + 1);       // free cell count
    localparam int PT_W    = $clog2(GRID_SIZE + 1) + FRAC_BITS + 1; // running point
    localparam int CIDX_W  = PT_W - 1 - FRAC_BITS;        // integer part of point

    // Axes
    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WALK,
        ST_LAST
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ rtl/vrw_if.sv @@
// Ray input and cell output channels with valid/ready handshake.
// Depends on vrw_pkg for field widths.
interface vrw_in_if
    import vrw_pkg::*;
    ();
    logic                          valid;
    logic                          ready;
    logic        [START_W-1:0]     start_x;
    logic        [START_W-1:0]     start_y;
    logic        [START_W-1:0]     start_z;
    logic signed [COORD_BITS-1:0]  target_x;
    logic signed [COORD_BITS-1:0]  target_y;
    logic signed [COORD_BITS-1:0]  target_z;

    modport source (output valid, start_x, start_y, start_z, target_x, target_y, target_z,
                    input ready);
    modport sink   (input valid, start_x, start_y, start_z, target_x, target_y, target_z,
                    output ready);
endinterface

interface vrw_out_if
    import vrw_pkg::*;
    ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  cell_x;
    logic signed [COORD_BITS-1:0]  cell_y;
    logic signed [COORD_BITS-1:0]  cell_z;
    logic                          is_hit;
    logic                          in_grid;
    logic                          last;

    modport source (output valid, cell_x, cell_y, cell_z, is_hit, in_grid, last,
                    input ready);
    modport sink   (input valid, cell_x, cell_y, cell_z, is_hit, in_grid, last,
                    output ready);
endinterface

@@ rtl/vrw_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Produces the rounded step increment magnitude; depends on vrw_pkg.
module vrw_div
    import vrw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [REM_W-1:0]  r_rem,  n_rem;
    logic [QUOT_W-1:0] r_num,  n_num;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [DEN_W-1:0]  r_den,  n_den;
    logic [REM_W-1:0]  w_trial;
    logic              w_fit;

    // Shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem[REM_W-2:0], r_num[QUOT_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    // Load on start, then one quotient bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_quot = r_quot;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(QUOT_W - 1);
            n_rem  = {{(REM_W - (NUM_W - QUOT_W)){1'b0}}, i_req.dividend[NUM_W-1:QUOT_W]};
            n_num  = i_req.dividend[QUOT_W-1:0];
            n_quot = '0;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            n_rem  = w_fit ? (w_trial - {1'b0, r_den}) : w_trial;
            n_quot = {r_quot[QUOT_W-2:0], w_fit};
            n_num  = {r_num[QUOT_W-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

`ifndef ASSERT_OFF
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < {1'b0, r_den}))
        else $error("divider remainder not below divisor");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
`endif

endmodule

@@ rtl/voxel_ray_walker_unit.sv @@
// Voxel ray walker: a ray transaction goes through one setup state, then each axis in turn in the shared
// divider; then one cell per cycle while the output is not stalled, end cell last.
// A ray occupies the block until its end cell is registered for output; k <= min(n, 32) the
// free cells walked, n the step count; an off-grid or zero-length ray gives no output.
// Reset is synchronous, active low, and returns the block to idle with no output.
// Depends on vrw_pkg, vrw_if and vrw_div.
module voxel_ray_walker_unit
    import vrw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    vrw_in_if.sink    i_ray,
    vrw_out_if.source o_cell
);

    t_state r_state, n_state;

    logic        [START_W-1:0]    r_s     [NUM_AXES];
    logic signed [COORD_BITS-1:0] r_t     [NUM_AXES];
    logic        [MAG_W-1:0]      r_mag   [NUM_AXES];
    logic                         r_neg   [NUM_AXES];
    logic signed [INC_W-1:0]      r_inc   [NUM_AXES];
    logic signed [PT_W-1:0]       r_pt    [NUM_AXES];
    logic signed [COORD_BITS-1:0] r_cell  [NUM_AXES];
    logic        [MAG_W-1:0]      r_n;
    logic        [KW-1:0]         r_limit;
    logic        [KW-1:0]         r_k;
    logic        [AXIS_W-1:0]     r_axis;
    logic                         r_ov;
    logic                         r_hit;
    logic                         r_ing;
    logic                         r_last;

    logic signed [DIFF_W-1:0]     w_d      [NUM_AXES];
    logic        [MAG_W-1:0]      w_mag    [NUM_AXES];
    logic signed [PT_W-1:0]       w_pt_nx  [NUM_AXES];
    logic        [NUM_AXES-1:0]   w_s_in;
    logic        [NUM_AXES-1:0]   w_nx_in;
    logic        [NUM_AXES-1:0]   w_t_in;
    logic        [MAG_W-1:0]      w_n01;
    logic        [MAG_W-1:0]      w_n;
    logic                         w_ray_ok;
    logic        [KW-1:0]         w_k_inc;
    logic                         w_walk_end;
    logic signed [INC_W-1:0]      w_inc;
    logic                         w_accept;
    logic                         w_slot_free;
    logic                         w_emit_free;
    logic                         w_emit_last;
    logic                         w_in_ready;
    t_div_req                     w_div_req;
    t_div_rsp                     w_div_rsp;

    // Per-axis difference, magnitude, next point and grid checks
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_d[a]     = DIFF_W'(r_t[a]) - $signed({{(DIFF_W - START_W){1'b0}}, r_s[a]});
            w_mag[a]   = w_d[a][DIFF_W-1] ? MAG_W'(-w_d[a]) : MAG_W'(w_d[a]);
            w_s_in[a]  = (r_s[a] < START_W'(GRID_SIZE));
            w_t_in[a]  = (r_t[a] >= 0) && (r_t[a] < $signed(COORD_BITS'(GRID_SIZE)));
            w_pt_nx[a] = r_pt[a] + PT_W'(r_inc[a]);
            w_nx_in[a] = !w_pt_nx[a][PT_W-1] &&
                         (w_pt_nx[a][PT_W-2:FRAC_BITS] < CIDX_W'(GRID_SIZE));
        end
    end

    // Step count is the largest axis magnitude
    assign w_n01    = (w_mag[1] > w_mag[0]) ? w_mag[1] : w_mag[0];
    assign w_n      = (w_mag[2] > w_n01) ? w_mag[2] : w_n01;
    assign w_ray_ok = (&w_s_in) && (w_n != '0);

    assign w_k_inc    = r_k + 1'b1;
    assign w_walk_end = !(&w_nx_in) || (w_k_inc == r_limit);

    // Signed increment from the divider quotient
    assign w_inc = r_neg[r_axis] ? -$signed({1'b0, w_div_rsp.quot})
                                 :  $signed({1'b0, w_div_rsp.quot});

    // Divider request: (2*|d|*2^F + n) / (2*n)
    assign w_div_req.start    = (r_state == ST_DIV_GO);
    assign w_div_req.dividend = {1'b0, r_mag[r_axis], {(FRAC_BITS + 1){1'b0}}}
                              + {{(NUM_W - MAG_W){1'b0}}, r_n};
    assign w_div_req.divisor  = {r_n, 1'b0};

    vrw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_ray.valid) n_state = ST_SETUP;
            ST_SETUP:    n_state = w_ray_ok ? ST_DIV_GO : ST_IDLE;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: if (w_div_rsp.done) n_state = (r_axis == AXIS_Z) ? ST_WALK : ST_DIV_GO;
            ST_WALK:     if (w_slot_free && w_walk_end) n_state = ST_LAST;
            ST_LAST:     if (w_slot_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_emit_free = 1'b0;
        w_emit_last = 1'b0;
        unique case (r_state)
            ST_IDLE:  w_in_ready  = 1'b1;
            ST_WALK:  w_emit_free = w_slot_free;
            ST_LAST:  w_emit_last = w_slot_free;
            default:  w_in_ready  = 1'b0;
        endcase
    end

    assign w_slot_free = !r_ov || o_cell.ready;
    assign w_accept    = i_ray.valid && w_in_ready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit_free || w_emit_last) begin
                r_ov <= 1'b1;
            end else if (o_cell.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Ray datapath: capture, setup, increments, point advance
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s[0] <= i_ray.start_x;
            r_s[1] <= i_ray.start_y;
            r_s[2] <= i_ray.start_z;
            r_t[0] <= i_ray.target_x;
            r_t[1] <= i_ray.target_y;
            r_t[2] <= i_ray.target_z;
        end
        if (r_state == ST_SETUP) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_mag[a] <= w_mag[a];
                r_neg[a] <= w_d[a][DIFF_W-1];
                r_pt[a]  <= $signed({{(PT_W - CELL_W - FRAC_BITS){1'b0}},
                                     r_s[a][CELL_W-1:0], {FRAC_BITS{1'b0}}});
            end
            r_n     <= w_n;
            r_limit <= (w_n < MAG_W'(GRID_SIZE)) ? w_n[KW-1:0] : KW'(GRID_SIZE);
            r_k     <= '0;
            r_axis  <= AXIS_X;
        end
        if ((r_state == ST_DIV_WAIT) && w_div_rsp.done) begin
            r_inc[r_axis] <= w_inc;
            r_axis        <= r_axis + 1'b1;
        end
        if (w_emit_free) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_pt[a] <= w_pt_nx[a];
            end
            r_k <= w_k_inc;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_emit_free) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_cell[a] <= COORD_BITS'(r_pt[a] >>> FRAC_BITS);
            end
            r_hit  <= 1'b0;
            r_ing  <= 1'b1;
            r_last <= 1'b0;
        end else if (w_emit_last) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_cell[a] <= r_t[a];
            end
            r_hit  <= 1'b1;
            r_ing  <= &w_t_in;
            r_last <= 1'b1;
        end
    end

    assign i_ray.ready    = w_in_ready;
    assign o_cell.valid   = r_ov;
    assign o_cell.cell_x  = r_cell[0];
    assign o_cell.cell_y  = r_cell[1];
    assign o_cell.cell_z  = r_cell[2];
    assign o_cell.is_hit  = r_hit;
    assign o_cell.in_grid = r_ing;
    assign o_cell.last    = r_last;

`ifndef ASSERT_OFF
    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_k < r_limit))
        else $error("free cell count reached its limit while walking");
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIV_WAIT))
        else $error("division finished outside the wait state");
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_last |=> ((r_state == ST_IDLE) && r_ov && r_last && r_hit))
        else $error("end cell not presented as the final result");
    a_free_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_free |=> (r_ing && !r_last && !r_hit))
        else $error("free cell result malformed");
`endif

endmodule
